FILE: rtl/positional_list_engine_unit_assert.svh
// Assertion macros used by the checker of the positional list engine.
`ifndef POSITIONAL_LIST_ENGINE_UNIT_ASSERT_SVH
`define POSITIONAL_LIST_ENGINE_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define PLE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define PLE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/ple_pkg.sv
`default_nettype none
package ple_pkg;

    localparam int DEPTH = 16;

    localparam int OP_W     = 2;
    localparam int POS_W    = 5;
    localparam int VALUE_W  = 32;
    localparam int FPOS_W   = 4;
    localparam int COUNT_W  = 5;

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (POS_W > CNT_W) ? POS_W : CNT_W;

    localparam int S_FIELDS_W = OP_W + POS_W + VALUE_W;
    localparam int S_DATA_W   = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_FIELDS_W = VALUE_W + FPOS_W + 1 + 1 + COUNT_W;
    localparam int M_DATA_W   = ((M_FIELDS_W + 7) / 8) * 8;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_READ   = 2'd2,
        OP_FIND   = 2'd3
    } op_t;

    // Command broadcast to every cell of the chain.
    typedef struct packed {
        logic                      insert_en;
        logic                      remove_en;
        logic [CMP_W-1:0]          position;
        logic signed [VALUE_W-1:0] value;
    } cell_cmd_t;

endpackage
`default_nettype wire

FILE: rtl/ple_cell.sv
`default_nettype none
module ple_cell
    import ple_pkg::*;
(
    input  wire logic                      aclk,
    input  wire logic [CMP_W-1:0]          cell_index,
    input  wire cell_cmd_t                 cmd,
    input  wire logic signed [VALUE_W-1:0] left_entry,
    input  wire logic signed [VALUE_W-1:0] right_entry,
    output logic signed [VALUE_W-1:0]      entry,
    output logic                           match
);

    logic signed [VALUE_W-1:0] entry_reg;
    logic signed [VALUE_W-1:0] entry_next;

    // On insert the cells behind the position take their left neighbour's entry;
    // on remove the cells from the position onwards take their right neighbour's.
    always_comb begin
        entry_next = entry_reg;
        if (cmd.insert_en) begin
            if (cell_index == cmd.position) begin
                entry_next = cmd.value;
            end else if (cell_index > cmd.position) begin
                entry_next = left_entry;
            end
        end else if (cmd.remove_en && (cell_index >= cmd.position)) begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;
    assign match = (entry_reg == cmd.value);

endmodule
`default_nettype wire

FILE: rtl/positional_list_engine_unit.sv
`default_nettype none
// Ordered list of up to DEPTH signed 32-bit values held in a chain of cells, one
// entry per cell. Each input transfer carries one operation (insert, remove,
// read or find) and yields exactly one result transfer. All cells shift towards
// or away from the head together; find compares every cell at once and picks
// the lowest live match. The result sits in an output register, so a new
// operation is taken in every cycle in which the result register is empty or
// being drained; the rate is one operation per cycle while m_tready stays high.
// A refused request (insert past the count or into a full list, remove or read
// at or past the count) sets the error flag and leaves the list unchanged.
module positional_list_engine_unit
    import ple_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    // op [1:0], position [6:2], value [38:7], zero padding above.
    input  wire logic [S_DATA_W-1:0] s_tdata,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    // read_value [31:0], found_position [35:32], found [36], error [37],
    // entry_count [42:38], zero padding above.
    output logic [M_DATA_W-1:0]      m_tdata
);

    op_t                       in_op;
    logic [POS_W-1:0]          in_position;
    logic signed [VALUE_W-1:0] in_value;
    logic                      accept;

    logic [CNT_W-1:0]          count_reg;
    logic [CNT_W-1:0]          count_next;
    logic                      m_valid_reg;
    logic                      m_valid_next;
    logic [M_FIELDS_W-1:0]     result_reg;
    logic [M_FIELDS_W-1:0]     result_next;

    logic [CMP_W-1:0]          pos_cmp;
    logic [CMP_W-1:0]          count_cmp;
    logic                      error;
    cell_cmd_t                 cmd;

    logic signed [VALUE_W-1:0] entry_w [DEPTH];
    logic [DEPTH-1:0]          match_w;
    logic [DEPTH-1:0]          live_match;
    logic                      found;
    logic [IDX_W-1:0]          found_idx;
    logic signed [VALUE_W-1:0] read_value;

    assign in_op       = op_t'(s_tdata[OP_W-1:0]);
    assign in_position = s_tdata[OP_W+POS_W-1:OP_W];
    assign in_value    = s_tdata[OP_W+POS_W+VALUE_W-1:OP_W+POS_W];

    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    assign pos_cmp   = CMP_W'(in_position);
    assign count_cmp = CMP_W'(count_reg);

    always_comb begin
        case (in_op)
            OP_INSERT: error = (pos_cmp > count_cmp) || (count_cmp == CMP_W'(DEPTH));
            OP_REMOVE: error = (pos_cmp >= count_cmp);
            OP_READ:   error = (pos_cmp >= count_cmp);
            default:   error = 1'b0;
        endcase
    end

    always_comb begin
        cmd.insert_en = accept && (in_op == OP_INSERT) && !error;
        cmd.remove_en = accept && (in_op == OP_REMOVE) && !error;
        cmd.position  = pos_cmp;
        cmd.value     = in_value;
    end

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic signed [VALUE_W-1:0] left_w;
        logic signed [VALUE_W-1:0] right_w;

        if (i == 0) begin : g_head
            assign left_w = entry_w[0];
        end else begin : g_body
            assign left_w = entry_w[i-1];
        end

        if (i == DEPTH - 1) begin : g_tail
            assign right_w = entry_w[DEPTH-1];
        end else begin : g_inner
            assign right_w = entry_w[i+1];
        end

        ple_cell u_cell (
            .aclk        (aclk),
            .cell_index  (CMP_W'(i)),
            .cmd         (cmd),
            .left_entry  (left_w),
            .right_entry (right_w),
            .entry       (entry_w[i]),
            .match       (match_w[i])
        );

        assign live_match[i] = match_w[i] && (CMP_W'(i) < count_cmp);
    end

    // Priority pick: the lowest live matching cell wins.
    always_comb begin
        found_idx = '0;
        for (int j = DEPTH - 1; j >= 0; j--) begin
            if (live_match[j]) begin
                found_idx = IDX_W'(j);
            end
        end
    end

    assign found = (in_op == OP_FIND) && (|live_match);

    always_comb begin
        read_value = '0;
        if ((in_op == OP_READ) && !error) begin
            read_value = entry_w[IDX_W'(in_position)];
        end
    end

    always_comb begin
        count_next = count_reg;
        if (cmd.insert_en) begin
            count_next = count_reg + CNT_W'(1);
        end else if (cmd.remove_en) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_comb begin
        result_next = result_reg;
        if (accept) begin
            result_next = {COUNT_W'(count_next), error, found,
                           found ? FPOS_W'(found_idx) : FPOS_W'(0), read_value};
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (accept) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        result_reg <= result_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_DATA_W'(result_reg);

endmodule
`default_nettype wire

FILE: rtl/ple_checker.sv
`default_nettype none
`include "positional_list_engine_unit_assert.svh"
module ple_checker
    import ple_pkg::*;
(
    input wire logic                aclk,
    input wire logic                aresetn,
    input wire logic                s_tvalid,
    input wire logic                s_tready,
    input wire logic [S_DATA_W-1:0] s_tdata,
    input wire logic                m_tvalid,
    input wire logic                m_tready,
    input wire logic [M_DATA_W-1:0] m_tdata
);

    localparam int ERR_BIT   = VALUE_W + FPOS_W + 1;
    localparam int FOUND_BIT = VALUE_W + FPOS_W;
    localparam int CNT_LO    = VALUE_W + FPOS_W + 2;

    logic input_seen;
    assign input_seen = s_tvalid && s_tready && (s_tdata[0] | !s_tdata[0]);

    // A stalled result keeps its value.
    `PLE_ASSERT_NEXT(a_result_holds, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")
    // Every accepted operation yields a result in the following cycle.
    `PLE_ASSERT_NEXT(a_result_follows, input_seen, m_tvalid, "accepted transfer produced no result")
    // A refused request never also reports a match.
    `PLE_ASSERT_NOW(a_err_not_found, m_tvalid, !(m_tdata[ERR_BIT] && m_tdata[FOUND_BIT]), "error and found both set")
    // A refused request returns no data.
    `PLE_ASSERT_NOW(a_err_no_data, m_tvalid && m_tdata[ERR_BIT], m_tdata[VALUE_W-1:0] == '0, "read data on error")
    // The count never exceeds the list capacity.
    `PLE_ASSERT_NOW(a_count_range, m_tvalid, m_tdata[CNT_LO+COUNT_W-1:CNT_LO] <= COUNT_W'(DEPTH), "entry count beyond capacity")

endmodule

bind positional_list_engine_unit ple_checker u_ple_checker (.*);
`default_nettype wire
